### hdl/ddb_pkg.sv
// Shared types and constants for the block DPCM decoder.
package ddb_pkg;

  // Block geometry: BLOCK_SAMPLES samples per block, one header plus deltas
  localparam int BLOCK_SAMPLES = 16;
  localparam int POS_W         = $clog2(BLOCK_SAMPLES + 1);

  // Dequantization table: eight maps of 256 entries
  localparam int MAP_COUNT   = 8;
  localparam int MAP_ENTRIES = 256;
  localparam int MAP_W       = $clog2(MAP_COUNT);
  localparam int ENTRY_W     = $clog2(MAP_ENTRIES);
  localparam int ADDR_W      = MAP_W + ENTRY_W;
  localparam int TABLE_DEPTH = MAP_COUNT * MAP_ENTRIES;

  // Sample arithmetic
  localparam int SAMPLE_W = 16;
  localparam int BYTE_W   = 8;
  localparam int PRED_W   = SAMPLE_W + 2;
  localparam int SUM_W    = SAMPLE_W + 3;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Stream positions
  localparam logic [POS_W-1:0] POS_HDR_LO = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR_HI = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_SAMPLES);

  // Item kinds
  localparam logic KIND_TABLE  = 1'b0;
  localparam logic KIND_STREAM = 1'b1;

  // Table port request, one access per accepted item
  typedef struct packed {
    logic                       en;
    logic                       we;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] wdata;
  } ram_req_t;

  // Item held in the lookup stage, waiting for the table read data
  typedef struct packed {
    logic                       is_start;
    logic                       last;
    logic                       linear;
    logic signed [SAMPLE_W-1:0] start_sample;
  } s1_item_t;

endpackage

### hdl/ddb_dequant_ram.sv
// Dequantization table memory: one port, registered read data.
module ddb_dequant_ram (
  input  logic                                clk,
  input  ddb_pkg::ram_req_t                   req,
  output logic signed [ddb_pkg::SAMPLE_W-1:0] rdata
);
  import ddb_pkg::*;

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];

  // Write or read, never both in one cycle
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

### hdl/ddb_stream_ctl.sv
// Stream parser: block position, header capture, table addressing, lookup stage.
module ddb_stream_ctl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                kind,
  input  logic [ddb_pkg::BYTE_W-1:0]          data_byte,
  input  logic [ddb_pkg::MAP_W-1:0]           table_map,
  input  logic [ddb_pkg::ENTRY_W-1:0]         table_index,
  input  logic signed [ddb_pkg::SAMPLE_W-1:0] table_value,
  input  logic                                move,
  output ddb_pkg::ram_req_t                   ram_req,
  output logic                                s1_valid,
  output ddb_pkg::s1_item_t                   s1_item
);
  import ddb_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] header_low;
  logic [MAP_W-1:0]  map_select;
  logic              linear;
  logic              stream_acc;
  logic              result_acc;

  assign stream_acc = accept && (kind == KIND_STREAM);
  assign result_acc = stream_acc && (pos != POS_HDR_LO);

  // Table access: writes use the item's address, deltas the current map
  always_comb begin
    ram_req.en    = accept;
    ram_req.we    = (kind == KIND_TABLE);
    ram_req.wdata = table_value;
    if (kind == KIND_TABLE) begin
      ram_req.addr = {table_map, table_index};
    end else begin
      ram_req.addr = {map_select, data_byte};
    end
  end

  // Block position and header state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= POS_HDR_LO;
      header_low <= '0;
      map_select <= '0;
      linear     <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      if (result_acc) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (stream_acc) begin
        if (pos == POS_HDR_LO) begin
          header_low <= data_byte;
          pos        <= POS_HDR_HI;
        end else if (pos == POS_HDR_HI) begin
          linear     <= header_low[0];
          map_select <= header_low[MAP_W:1];
          pos        <= pos + POS_W'(1);
        end else if (pos == POS_LAST) begin
          pos <= POS_HDR_LO;
        end else begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  // Lookup stage payload
  always_ff @(posedge clk) begin
    if (result_acc) begin
      s1_item.is_start     <= (pos == POS_HDR_HI);
      s1_item.last         <= (pos == POS_LAST);
      s1_item.linear       <= (pos == POS_HDR_HI) ? header_low[0] : linear;
      s1_item.start_sample <= {data_byte, header_low};
    end
  end

endmodule

### hdl/ddb_predictor.sv
// Prediction, delta add with saturation, sample history and output register.
module ddb_predictor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s1_valid,
  input  ddb_pkg::s1_item_t                   s1_item,
  input  logic signed [ddb_pkg::SAMPLE_W-1:0] delta,
  input  logic                                out_stall,
  output logic                                move,
  output logic                                out_valid,
  output logic signed [ddb_pkg::SAMPLE_W-1:0] sample,
  output logic                                last_of_block
);
  import ddb_pkg::*;

  logic signed [SAMPLE_W-1:0] prev_sample;
  logic signed [SAMPLE_W-1:0] older_sample;
  logic signed [PRED_W-1:0]   pred;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sat_sample;
  logic signed [SAMPLE_W-1:0] new_sample;
  logic                       out_free;

  assign out_free = !out_valid || !out_stall;
  assign move     = s1_valid && out_free;

  // Hold or linear prediction, then add and clamp; start items pass through
  always_comb begin
    if (s1_item.linear) begin
      pred = (PRED_W'(prev_sample) <<< 1) - PRED_W'(older_sample);
    end else begin
      pred = PRED_W'(prev_sample);
    end
    sum = SUM_W'(pred) + SUM_W'(delta);
    if (sum > SUM_W'(SAMPLE_MAX)) begin
      sat_sample = SAMPLE_MAX;
    end else if (sum < SUM_W'(SAMPLE_MIN)) begin
      sat_sample = SAMPLE_MIN;
    end else begin
      sat_sample = sum[SAMPLE_W-1:0];
    end
    new_sample = s1_item.is_start ? s1_item.start_sample : sat_sample;
  end

  // History and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample  <= '0;
      older_sample <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (move) begin
        prev_sample  <= new_sample;
        older_sample <= s1_item.is_start ? s1_item.start_sample : prev_sample;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (move) begin
      sample        <= new_sample;
      last_of_block <= s1_item.last;
    end
  end

endmodule

### hdl/ddpcm_block_decoder.sv
// Block DPCM audio decoder top level.
// Header-high and delta bytes pass the lookup stage, then the output register.
// One item per cycle unless the output stalls; table read and add share no unit.
// Table writes and header-low bytes are taken and give no sample.
// Reset clears block position, header, history and valids; the dequant table
// keeps its contents and holds nothing meaningful until written.
module ddpcm_block_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [ddb_pkg::BYTE_W-1:0]          data_byte,
  input  logic [ddb_pkg::MAP_W-1:0]           table_map,
  input  logic [ddb_pkg::ENTRY_W-1:0]         table_index,
  input  logic signed [ddb_pkg::SAMPLE_W-1:0] table_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ddb_pkg::SAMPLE_W-1:0] sample,
  output logic                                last_of_block
);
  import ddb_pkg::*;

  logic                       accept;
  logic                       move;
  logic                       s1_valid;
  s1_item_t                   s1_item;
  ram_req_t                   ram_req;
  logic signed [SAMPLE_W-1:0] delta;

  // Stall only when the lookup stage is full and cannot drain
  assign in_stall = s1_valid && !move;
  assign accept   = in_valid && !in_stall;

  ddb_stream_ctl u_ctl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (kind),
    .data_byte   (data_byte),
    .table_map   (table_map),
    .table_index (table_index),
    .table_value (table_value),
    .move        (move),
    .ram_req     (ram_req),
    .s1_valid    (s1_valid),
    .s1_item     (s1_item)
  );

  ddb_dequant_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (delta)
  );

  ddb_predictor u_pred (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_item       (s1_item),
    .delta         (delta),
    .out_stall     (out_stall),
    .move          (move),
    .out_valid     (out_valid),
    .sample        (sample),
    .last_of_block (last_of_block)
  );

  // Input stalls only behind a blocked output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output could drain");

  // A new sample always comes from the lookup stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("output valid without a staged item");

  // A staged item that cannot move stays staged
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !move) |=> s1_valid)
    else $error("staged item lost while blocked");

endmodule
